@@ src/ple_pkg.sv @@
// Shared types and codes for the positional list engine.
package ple_pkg;

   // Operation codes carried by a request transaction.
   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_TRAVERSE  = 3'd6
   } op_type;

   // Status codes carried by a response transaction.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_BAD_POS = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_GRAB,
      ST_SHIFT_DN,
      ST_TRAV,
      ST_RESP
   } state_type;

   // One response transaction as it moves into the output register.
   typedef struct packed {
      status_type         status;
      logic signed [31:0] result_value;
      logic               value_valid;
      logic               last;
   } rsp_type;

endpackage

@@ src/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer around the value RAM.
//
//   channel | ports                                         | direction
//   req     | req_valid req_stall req_operation req_position | in
//           | req_item_value                                 |
//   rsp     | rsp_valid rsp_stall rsp_status                 | out
//           | rsp_result_value rsp_value_valid rsp_last      |
//
// Elements sit packed in order in one RAM with a registered read; a shift moves one
// element per cycle through its read and write ports. An insert moves the elements
// from its slot onward up by one, last first; a delete fetches the removed element
// and moves the elements behind it down. A traverse sends one response per element.
// Synchronous reset empties the list; RAM contents are never cleared.
// A stalled response holds in the output register; requests wait while busy.
module positional_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_operation,
   input  logic [5:0]          req_position,
   input  logic signed [31:0]  req_item_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_value_valid,
   output logic                rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > 6) ? LW : 6) + 1;

   ple_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [31:0]        val_ff, val_in;
   ple_pkg::rsp_type   res_ff, res_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [31:0]        ram_rdata;

   logic               load_valid;
   ple_pkg::rsp_type   load_data;
   logic               can_load;

   logic [CW-1:0]      pos_w;
   logic [CW-1:0]      len_w;
   logic               is_full;
   logic               is_empty;
   logic               ins_bad;
   logic               del_bad;
   logic [AW-1:0]      ins_idx;
   logic [AW-1:0]      del_idx;

   // Value store.
   ple_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Response output register.
   ple_rsp_reg u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (load_valid),
      .load_data        (load_data),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_value_valid  (rsp_value_valid),
      .rsp_last         (rsp_last)
   );

   // Requests are taken only while the sequencer is idle.
   assign req_stall = (state_ff != ple_pkg::ST_IDLE);

   // Position checks and slot selection for the incoming request.
   always_comb begin
      pos_w    = CW'(req_position);
      len_w    = CW'(len_ff);
      is_full  = (len_ff == LW'(CAPACITY));
      is_empty = (len_ff == '0);
      ins_bad  = (req_position == '0) || (pos_w > len_w + CW'(1));
      del_bad  = (req_position == '0) || (pos_w > len_w);
      case (ple_pkg::op_type'(req_operation))
         ple_pkg::OP_INS_FRONT: ins_idx = '0;
         ple_pkg::OP_INS_END:   ins_idx = AW'(len_ff);
         default:               ins_idx = AW'(pos_w - CW'(1));
      endcase
      case (ple_pkg::op_type'(req_operation))
         ple_pkg::OP_DEL_FRONT: del_idx = '0;
         ple_pkg::OP_DEL_END:   del_idx = AW'(len_ff - LW'(1));
         default:               del_idx = AW'(pos_w - CW'(1));
      endcase
   end

   // Sequencer: next state, RAM accesses and response loading.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = pend_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = cur_ff;
      load_valid   = 1'b0;
      load_data    = res_ff;

      case (state_ff)
         ple_pkg::ST_IDLE: begin
            pend_in = 1'b0;
            res_in  = '{status: ple_pkg::STATUS_OK, result_value: '0,
                        value_valid: 1'b0, last: 1'b1};
            if (req_valid) begin
               case (ple_pkg::op_type'(req_operation))
                  ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_END, ple_pkg::OP_INS_AT: begin
                     if ((ple_pkg::op_type'(req_operation) == ple_pkg::OP_INS_AT)
                         && ins_bad) begin
                        res_in.status = ple_pkg::STATUS_BAD_POS;
                        state_in      = ple_pkg::ST_RESP;
                     end else if (is_full) begin
                        res_in.status = ple_pkg::STATUS_FULL;
                        state_in      = ple_pkg::ST_RESP;
                     end else begin
                        // Move the tail up by one, starting from the last element.
                        idx_in   = ins_idx;
                        cnt_in   = len_ff - LW'(ins_idx);
                        cur_in   = AW'(len_ff - LW'(1));
                        val_in   = req_item_value;
                        state_in = ple_pkg::ST_SHIFT_UP;
                     end
                  end
                  ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_END, ple_pkg::OP_DEL_AT: begin
                     if (is_empty) begin
                        res_in.status = ple_pkg::STATUS_EMPTY;
                        state_in      = ple_pkg::ST_RESP;
                     end else if ((ple_pkg::op_type'(req_operation) == ple_pkg::OP_DEL_AT)
                                  && del_bad) begin
                        res_in.status = ple_pkg::STATUS_BAD_POS;
                        state_in      = ple_pkg::ST_RESP;
                     end else begin
                        // Fetch the removed element, then move the tail down.
                        ram_re    = 1'b1;
                        ram_raddr = del_idx;
                        idx_in    = del_idx;
                        cur_in    = del_idx + AW'(1);
                        cnt_in    = len_ff - LW'(1) - LW'(del_idx);
                        state_in  = ple_pkg::ST_GRAB;
                     end
                  end
                  ple_pkg::OP_TRAVERSE: begin
                     if (is_empty) begin
                        res_in.status = ple_pkg::STATUS_EMPTY;
                        state_in      = ple_pkg::ST_RESP;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        cur_in    = AW'(1);
                        cnt_in    = len_ff;
                        state_in  = ple_pkg::ST_TRAV;
                     end
                  end
                  default: begin
                     // Unused operation code: taken and dropped.
                     state_in = ple_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         ple_pkg::ST_SHIFT_UP, ple_pkg::ST_SHIFT_DN: begin
            // Write back the element read in the previous cycle.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (cnt_ff != '0) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff - LW'(1);
               if (state_ff == ple_pkg::ST_SHIFT_UP) begin
                  pend_addr_in = cur_ff + AW'(1);
                  cur_in       = cur_ff - AW'(1);
               end else begin
                  pend_addr_in = cur_ff - AW'(1);
                  cur_in       = cur_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // Shift done: place the new element or drop the count.
                  state_in = ple_pkg::ST_RESP;
                  if (state_ff == ple_pkg::ST_SHIFT_UP) begin
                     ram_we    = 1'b1;
                     ram_waddr = idx_ff;
                     ram_wdata = val_ff;
                     len_in    = len_ff + LW'(1);
                  end else begin
                     len_in              = len_ff - LW'(1);
                     res_in.result_value = val_ff;
                     res_in.value_valid  = 1'b1;
                  end
               end
            end
         end

         ple_pkg::ST_GRAB: begin
            val_in   = ram_rdata;
            state_in = ple_pkg::ST_SHIFT_DN;
         end

         ple_pkg::ST_TRAV: begin
            // Read data holds until the next read, so a stalled output just waits.
            if (can_load) begin
               load_valid = 1'b1;
               load_data  = '{status: ple_pkg::STATUS_OK, result_value: ram_rdata,
                              value_valid: 1'b1, last: (cnt_ff == LW'(1))};
               cnt_in     = cnt_ff - LW'(1);
               if (cnt_ff == LW'(1)) begin
                  state_in = ple_pkg::ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = cur_ff;
                  cur_in    = cur_ff + AW'(1);
               end
            end
         end

         ple_pkg::ST_RESP: begin
            if (can_load) begin
               load_valid = 1'b1;
               load_data  = res_ff;
               state_in   = ple_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ple_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::ST_IDLE;
         len_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      val_ff       <= val_in;
      res_ff       <= res_in;
   end

endmodule

@@ src/ple_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ple_rsp_reg.sv @@
// Output register that holds one response transaction until it is taken.
module ple_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  ple_pkg::rsp_type    load_data,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_value_valid,
   output logic                rsp_last
);

   logic             valid_ff;
   logic             valid_in;
   ple_pkg::rsp_type data_ff;

   // The slot is free when empty or when its transaction leaves this cycle.
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = can_load ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is captured only on a load, so a stalled transaction holds.
   always_ff @(posedge clock) begin
      if (can_load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = data_ff.status;
   assign rsp_result_value = data_ff.result_value;
   assign rsp_value_valid  = data_ff.value_valid;
   assign rsp_last         = data_ff.last;

endmodule
